// ===== hw/rtl/cpu_io_math_irq_pad_registers_assert.svh =====
// Assertion macros for the CPU I/O register block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CPU_IO_MATH_IRQ_PAD_REGISTERS_ASSERT_SVH
`define CPU_IO_MATH_IRQ_PAD_REGISTERS_ASSERT_SVH
// Implication check, disabled in reset.
`define CIO_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication check, disabled in reset.
`define CIO_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== hw/rtl/cio_pkg.sv =====
// Shared types and constants for the CPU I/O register block.
// No dependencies.
package cio_pkg;
  typedef enum logic [2:0] {
    MODE_READ = 3'd0, MODE_WRITE = 3'd1, MODE_HBLANK = 3'd2,
    MODE_VBLANK = 3'd3, MODE_SETPAD = 3'd4, MODE_NMIACK = 3'd5
  } mode_t;

  localparam logic [9:0] OFF_JOY0   = 10'h016;
  localparam logic [9:0] OFF_JOY1   = 10'h017;
  localparam logic [9:0] OFF_INTEN  = 10'h200;
  localparam logic [9:0] OFF_IOPORT = 10'h201;
  localparam logic [9:0] OFF_MULA   = 10'h202;
  localparam logic [9:0] OFF_MULB   = 10'h203;
  localparam logic [9:0] OFF_DIVL   = 10'h204;
  localparam logic [9:0] OFF_DIVH   = 10'h205;
  localparam logic [9:0] OFF_DIVB   = 10'h206;
  localparam logic [9:0] OFF_HTL    = 10'h207;
  localparam logic [9:0] OFF_HTH    = 10'h208;
  localparam logic [9:0] OFF_VTL    = 10'h209;
  localparam logic [9:0] OFF_VTH    = 10'h20A;
  localparam logic [9:0] OFF_ROMSPD = 10'h20D;
  localparam logic [9:0] OFF_NMIST  = 10'h210;
  localparam logic [9:0] OFF_TIMEUP = 10'h211;
  localparam logic [9:0] OFF_HVBST  = 10'h212;
  localparam logic [9:0] OFF_RDIO   = 10'h213;
  localparam logic [9:0] OFF_QL     = 10'h214;
  localparam logic [9:0] OFF_QH     = 10'h215;
  localparam logic [9:0] OFF_RL     = 10'h216;
  localparam logic [9:0] OFF_RH     = 10'h217;
  localparam logic [9:0] OFF_P0L    = 10'h218;
  localparam logic [9:0] OFF_P0H    = 10'h219;
  localparam logic [9:0] OFF_P1L    = 10'h21A;
  localparam logic [9:0] OFF_P1H    = 10'h21B;

  localparam logic [8:0] VBLANK_LINE = 9'd225;
  localparam logic [8:0] HBLANK_DOT  = 9'd274;
  localparam int unsigned DIV_STEPS  = 16;

  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  reg_offset;
    logic [7:0]  write_data;
    logic [8:0]  scanline;
    logic [8:0]  dot;
    logic        pad_index;
    logic [11:0] pad_buttons;
  } item_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;       // apply one item (all but divide finish)
    logic div_step;   // one restoring divide step
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_start;  // executed item started a divide
    logic div_done;   // last divide step in progress
  } sts_t;

  function automatic logic [15:0] remap_buttons(input logic [11:0] b);
    logic [15:0] r;
    r = '0;
    r[7] = b[0];  r[15] = b[1]; r[6] = b[2];  r[14] = b[3];
    r[5] = b[4];  r[4] = b[5];  r[12] = b[6]; r[13] = b[7];
    r[11] = b[8]; r[10] = b[9]; r[9] = b[10]; r[8] = b[11];
    return r;
  endfunction
endpackage

// ===== hw/rtl/cio_ctrl.sv =====
// Controller for the CPU I/O register block: sequences item execution,
// divide iterations and result delivery. Uses cio_pkg.
module cio_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output cio_pkg::cmd_t cmd,
  input  cio_pkg::sts_t sts
);
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;
  state_t state_r;
  logic   out_valid_r;

  // accept new item when idle or the held result leaves this cycle
  assign in_tready  = (state_r == S_IDLE) || (state_r == S_OUT && out_tready);
  assign out_tvalid = out_valid_r;
  assign cmd.exec     = in_tvalid && in_tready;
  assign cmd.div_step = (state_r == S_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE, S_OUT: begin
          if (cmd.exec) begin
            if (sts.div_start) begin
              state_r     <= S_DIV;
              out_valid_r <= 1'b0;
            end else begin
              state_r     <= S_OUT;
              out_valid_r <= 1'b1;
            end
          end else if (state_r == S_OUT && out_tready) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b0;
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            state_r     <= S_OUT;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  `include "cpu_io_math_irq_pad_registers_assert.svh"
  `CIO_ASSERT_IMP(a_valid_in_out, clk, rst_n, out_valid_r, state_r == S_OUT)
  `CIO_ASSERT_IMP(a_no_accept_div, clk, rst_n, state_r == S_DIV, !in_tready)
  `CIO_ASSERT_NXT(a_div_follows, clk, rst_n, cmd.exec && sts.div_start, state_r == S_DIV)
endmodule

// ===== hw/rtl/cio_dp.sv =====
// Datapath for the CPU I/O register block: register file, multiplier,
// iterative divider, pads, interrupt flags. Uses cio_pkg.
module cio_dp #(
  parameter int PAD_COUNT = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cio_pkg::item_t item,
  input  cio_pkg::cmd_t  cmd,
  output cio_pkg::sts_t  sts,
  output logic [7:0]     read_data,
  output logic           timer_irq,
  output logic           nmi_pending
);
  localparam int CW = $clog2(cio_pkg::DIV_STEPS);

  logic [7:0]  nmi_status_r, int_enable_r, io_port_r, mul_a_r, divisor_r;
  logic [7:0]  open_bus_r, rom_speed_r, rd_r;
  logic        timer_flag_r, irq_flag_r, nmi_request_r;
  logic [15:0] dividend_r, quotient_r, prod_rem_r;
  logic [8:0]  h_cmp_r, v_cmp_r;
  logic [15:0] pad_state_r [2];
  logic [15:0] pad_shift_r [2];
  logic [CW-1:0] cnt_r;

  logic is_rd, is_wr;
  logic [15:0] pad0, pad1;
  logic [8:0]  sub;
  logic [8:0]  rem_sh;

  assign is_rd = item.mode == cio_pkg::MODE_READ;
  assign is_wr = item.mode == cio_pkg::MODE_WRITE;
  assign pad0  = pad_state_r[0];
  assign pad1  = (PAD_COUNT > 1) ? pad_state_r[1] : 16'd0;

  assign sts.div_start = is_wr && item.reg_offset == cio_pkg::OFF_DIVB && item.write_data != 8'd0;
  assign sts.div_done  = cmd.div_step && cnt_r == CW'(cio_pkg::DIV_STEPS - 1);

  // restoring step: remainder in prod_rem_r, dividend bits shift through quotient_r
  assign rem_sh = {prod_rem_r[7:0], quotient_r[15]};
  assign sub    = rem_sh - {1'b0, divisor_r};

  assign read_data   = rd_r;
  assign timer_irq   = irq_flag_r;
  assign nmi_pending = nmi_request_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nmi_status_r <= '0; int_enable_r <= '0; io_port_r <= '0; mul_a_r <= '0;
      divisor_r <= '0; open_bus_r <= '0; rom_speed_r <= '0; rd_r <= '0;
      timer_flag_r <= 1'b0; irq_flag_r <= 1'b0; nmi_request_r <= 1'b0;
      dividend_r <= '0; quotient_r <= '0; prod_rem_r <= '0;
      h_cmp_r <= '0; v_cmp_r <= '0; cnt_r <= '0;
      pad_state_r[0] <= '0; pad_state_r[1] <= '0;
      pad_shift_r[0] <= '0; pad_shift_r[1] <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + CW'(1);
      if (!sub[8]) begin
        prod_rem_r <= {8'd0, sub[7:0]};
        quotient_r <= {quotient_r[14:0], 1'b1};
      end else begin
        prod_rem_r <= {7'd0, rem_sh};
        quotient_r <= {quotient_r[14:0], 1'b0};
      end
    end else if (cmd.exec) begin
      rd_r <= 8'd0;
      case (item.mode)
        cio_pkg::MODE_READ: begin
          case (item.reg_offset)
            cio_pkg::OFF_JOY0: begin
              rd_r <= {7'd0, pad_shift_r[0][0]};
              pad_shift_r[0] <= {1'b1, pad_shift_r[0][15:1]};
            end
            cio_pkg::OFF_JOY1: begin
              rd_r <= {7'd0, pad_shift_r[1][0]};
              pad_shift_r[1] <= {1'b1, pad_shift_r[1][15:1]};
            end
            cio_pkg::OFF_NMIST: begin
              rd_r <= nmi_status_r;
              nmi_status_r <= {1'b0, nmi_status_r[6:0]};
            end
            cio_pkg::OFF_TIMEUP: begin
              rd_r <= {timer_flag_r, 7'd0};
              timer_flag_r <= 1'b0;
              irq_flag_r <= 1'b0;
            end
            cio_pkg::OFF_HVBST: rd_r <= {item.scanline >= cio_pkg::VBLANK_LINE,
                                        item.dot >= cio_pkg::HBLANK_DOT, 6'd0};
            cio_pkg::OFF_RDIO: rd_r <= io_port_r;
            cio_pkg::OFF_QL:   rd_r <= quotient_r[7:0];
            cio_pkg::OFF_QH:   rd_r <= quotient_r[15:8];
            cio_pkg::OFF_RL:   rd_r <= prod_rem_r[7:0];
            cio_pkg::OFF_RH:   rd_r <= prod_rem_r[15:8];
            cio_pkg::OFF_P0L:  rd_r <= pad0[7:0];
            cio_pkg::OFF_P0H:  rd_r <= pad0[15:8];
            cio_pkg::OFF_P1L:  rd_r <= pad1[7:0];
            cio_pkg::OFF_P1H:  rd_r <= pad1[15:8];
            default: rd_r <= open_bus_r;
          endcase
        end
        cio_pkg::MODE_WRITE: begin
          open_bus_r <= item.write_data;
          case (item.reg_offset)
            cio_pkg::OFF_JOY0: if (item.write_data[0]) begin
              pad_shift_r[0] <= pad0;
              pad_shift_r[1] <= pad1;
            end
            cio_pkg::OFF_INTEN:  int_enable_r <= item.write_data;
            cio_pkg::OFF_IOPORT: io_port_r <= item.write_data;
            cio_pkg::OFF_MULA:   mul_a_r <= item.write_data;
            cio_pkg::OFF_MULB:   prod_rem_r <= {8'd0, mul_a_r} * {8'd0, item.write_data};
            cio_pkg::OFF_DIVL:   dividend_r[7:0] <= item.write_data;
            cio_pkg::OFF_DIVH:   dividend_r[15:8] <= item.write_data;
            cio_pkg::OFF_DIVB: begin
              divisor_r <= item.write_data;
              cnt_r <= '0;
              if (item.write_data == 8'd0) begin
                quotient_r <= 16'hFFFF;
                prod_rem_r <= dividend_r;
              end else begin
                quotient_r <= dividend_r;
                prod_rem_r <= 16'd0;
              end
            end
            cio_pkg::OFF_HTL: h_cmp_r[7:0] <= item.write_data;
            cio_pkg::OFF_HTH: h_cmp_r[8] <= item.write_data[0];
            cio_pkg::OFF_VTL: v_cmp_r[7:0] <= item.write_data;
            cio_pkg::OFF_VTH: v_cmp_r[8] <= item.write_data[0];
            cio_pkg::OFF_ROMSPD: rom_speed_r <= item.write_data;
            default: ;
          endcase
        end
        cio_pkg::MODE_HBLANK: begin
          if (int_enable_r[4] && item.dot >= h_cmp_r &&
              (!int_enable_r[5] || item.scanline == v_cmp_r)) begin
            irq_flag_r <= 1'b1;
            timer_flag_r <= 1'b1;
          end
        end
        cio_pkg::MODE_VBLANK: begin
          nmi_status_r <= 8'h82;
          if (int_enable_r[7]) nmi_request_r <= 1'b1;
          if (int_enable_r[0]) begin
            pad_shift_r[0] <= pad0;
            pad_shift_r[1] <= pad1;
          end
          if (int_enable_r[5] && !int_enable_r[4] && item.scanline == v_cmp_r) begin
            irq_flag_r <= 1'b1;
            timer_flag_r <= 1'b1;
          end
        end
        cio_pkg::MODE_SETPAD: begin
          if (int'(item.pad_index) < PAD_COUNT)
            pad_state_r[item.pad_index] <= cio_pkg::remap_buttons(item.pad_buttons);
        end
        cio_pkg::MODE_NMIACK: nmi_request_r <= 1'b0;
        default: ;
      endcase
    end
  end

  `include "cpu_io_math_irq_pad_registers_assert.svh"
  `CIO_ASSERT_IMP(a_irq_timer, clk, rst_n, irq_flag_r, timer_flag_r)
  `CIO_ASSERT_NXT(a_wr_openbus, clk, rst_n, cmd.exec && is_wr, open_bus_r == $past(item.write_data))
  `CIO_ASSERT_NXT(a_nonread_zero, clk, rst_n, cmd.exec && !is_rd, rd_r == 8'd0)
endmodule

// ===== hw/rtl/cpu_io_math_irq_pad_registers.sv =====
// Top level of the CPU I/O register block: math units, pads, IRQ/NMI.
// Instantiates cio_ctrl and cio_dp; uses cio_pkg.
//
//  channel | dir | tdata fields (low bit first)                       | tuser
//  in_     | in  | mode,reg_offset,write_data,scanline,dot,pad_index,  | -
//          |     | pad_buttons (52 bits, zero-filled to 56)            |
//  out_    | out | read_data,timer_irq,nmi_pending (10 -> 16 bits)     | -
//
// A write of a nonzero divisor runs the restoring 16/8 divider, which retires
// one quotient bit per cycle and takes no new item until it is done.
// A result sits in the output register until transferred; a new item is
// taken in the same cycle the held result leaves. Reset (rst_n low,
// synchronous) clears all state to zero.
module cpu_io_math_irq_pad_registers #(
  parameter int PAD_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // mode[2:0] reg_offset[12:3] write_data[20:13]
                                  // scanline[29:21] dot[38:30] pad_index[39]
                                  // pad_buttons[51:40]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data[7:0] timer_irq[8] nmi_pending[9]
);
  cio_pkg::item_t item;
  cio_pkg::cmd_t  cmd;
  cio_pkg::sts_t  sts;
  logic [7:0] rd;
  logic irq, nmi;

  // unpack the transfer
  assign item.mode        = in_tdata[2:0];
  assign item.reg_offset  = in_tdata[12:3];
  assign item.write_data  = in_tdata[20:13];
  assign item.scanline    = in_tdata[29:21];
  assign item.dot         = in_tdata[38:30];
  assign item.pad_index   = in_tdata[39];
  assign item.pad_buttons = in_tdata[51:40];

  cio_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd, .sts
  );

  cio_dp #(.PAD_COUNT(PAD_COUNT)) u_dp (
    .clk, .rst_n, .item, .cmd, .sts,
    .read_data(rd), .timer_irq(irq), .nmi_pending(nmi)
  );

  assign out_tdata = {6'd0, nmi, irq, rd};
endmodule

// ===== test/tb_top.sv =====
// Testbench for the CPU I/O register block: bus reads and writes, math units,
// pads, timer IRQ and vblank NMI. Uses cio_pkg and the top level of the block.
`timescale 1ns / 100ps

module tb_top;

  localparam int  PADS        = 2;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  N_RANDOM    = 1500;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // mode, reg_offset, write_data, scanline, dot, pad_index,
                           // pad_buttons
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // read_data, timer_irq, nmi_pending

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
    logic       nmi_pending;
  } io_result_t;

  // One row of directed stimulus; has_exp marks rows whose result is typed in.
  typedef struct {
    cio_pkg::item_t item;
    logic           has_exp;
    io_result_t     exp;
  } dir_row_t;

  // Mirror of the register block state.
  logic [7:0]  nmi_status;
  logic        timer_flag;
  logic        irq_flag;
  logic        nmi_request;
  logic [7:0]  int_enable;
  logic [7:0]  io_port;
  logic [7:0]  mul_a;
  logic [7:0]  divisor;
  logic [15:0] dividend;
  logic [15:0] quotient;
  logic [15:0] prod_rem;
  logic [8:0]  h_compare;
  logic [8:0]  v_compare;
  logic [15:0] pad_state [PADS];
  logic [15:0] pad_shift [PADS];
  logic [7:0]  open_bus;
  logic [7:0]  rom_speed;

  io_result_t expected_results[$];
  logic       failed;
  int         cycle_count;
  dir_row_t   dir_rows[$];

  cpu_io_math_irq_pad_registers #(.PAD_COUNT(PADS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Hard stop on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [15:0] pad_layout(input logic [11:0] b);
    logic [15:0] r;
    r = '0;
    // Host order A,B,X,Y,L,R,Start,Select,Up,Down,Left,Right to console order.
    if (b[0])  r |= 16'h0080;
    if (b[1])  r |= 16'h8000;
    if (b[2])  r |= 16'h0040;
    if (b[3])  r |= 16'h4000;
    if (b[4])  r |= 16'h0020;
    if (b[5])  r |= 16'h0010;
    if (b[6])  r |= 16'h1000;
    if (b[7])  r |= 16'h2000;
    if (b[8])  r |= 16'h0800;
    if (b[9])  r |= 16'h0400;
    if (b[10]) r |= 16'h0200;
    if (b[11]) r |= 16'h0100;
    return r;
  endfunction

  task automatic clear_mirror();
    nmi_status = '0; timer_flag = 0; irq_flag = 0; nmi_request = 0;
    int_enable = '0; io_port = '0; mul_a = '0; divisor = '0;
    dividend = '0; quotient = '0; prod_rem = '0;
    h_compare = '0; v_compare = '0; open_bus = '0; rom_speed = '0;
    for (int p = 0; p < PADS; p++) begin
      pad_state[p] = '0;
      pad_shift[p] = '0;
    end
  endtask

  // Serial pad bit: take bit 0, shift right, fill a one at the top.
  task automatic shift_pad(input int p, output logic [7:0] bit_out);
    bit_out = {7'd0, pad_shift[p][0]};
    pad_shift[p] = {1'b1, pad_shift[p][15:1]};
  endtask

  task automatic predict_read(input cio_pkg::item_t it, output logic [7:0] rd);
    rd = open_bus;
    case (it.reg_offset)
      cio_pkg::OFF_JOY0: shift_pad(0, rd);
      cio_pkg::OFF_JOY1: shift_pad(1, rd);
      cio_pkg::OFF_NMIST: begin
        rd = nmi_status;
        nmi_status[7] = 1'b0;
      end
      cio_pkg::OFF_TIMEUP: begin
        rd = timer_flag ? 8'h80 : 8'h00;
        timer_flag = 0;
        irq_flag = 0;
      end
      cio_pkg::OFF_HVBST: begin
        rd = 8'h00;
        if (it.scanline >= cio_pkg::VBLANK_LINE) rd[7] = 1'b1;
        if (it.dot >= cio_pkg::HBLANK_DOT)       rd[6] = 1'b1;
      end
      cio_pkg::OFF_RDIO: rd = io_port;
      cio_pkg::OFF_QL:   rd = quotient[7:0];
      cio_pkg::OFF_QH:   rd = quotient[15:8];
      cio_pkg::OFF_RL:   rd = prod_rem[7:0];
      cio_pkg::OFF_RH:   rd = prod_rem[15:8];
      cio_pkg::OFF_P0L:  rd = pad_state[0][7:0];
      cio_pkg::OFF_P0H:  rd = pad_state[0][15:8];
      cio_pkg::OFF_P1L:  rd = pad_state[1][7:0];
      cio_pkg::OFF_P1H:  rd = pad_state[1][15:8];
      default: ;
    endcase
  endtask

  task automatic predict_write(input cio_pkg::item_t it);
    logic [7:0] v;
    v = it.write_data;
    open_bus = v;
    case (it.reg_offset)
      cio_pkg::OFF_JOY0: if (v[0]) begin
        for (int p = 0; p < PADS; p++) pad_shift[p] = pad_state[p];
      end
      cio_pkg::OFF_INTEN:  int_enable = v;
      cio_pkg::OFF_IOPORT: io_port = v;
      cio_pkg::OFF_MULA:   mul_a = v;
      cio_pkg::OFF_MULB:   prod_rem = mul_a * v;
      cio_pkg::OFF_DIVL:   dividend[7:0] = v;
      cio_pkg::OFF_DIVH:   dividend[15:8] = v;
      cio_pkg::OFF_DIVB: begin
        divisor = v;
        if (v != 0) begin
          quotient = dividend / v;
          prod_rem = dividend % v;
        end else begin
          // Divide by zero: all-ones quotient, remainder keeps the dividend.
          quotient = 16'hFFFF;
          prod_rem = dividend;
        end
      end
      cio_pkg::OFF_HTL:    h_compare[7:0] = v;
      cio_pkg::OFF_HTH:    h_compare[8] = v[0];
      cio_pkg::OFF_VTL:    v_compare[7:0] = v;
      cio_pkg::OFF_VTH:    v_compare[8] = v[0];
      cio_pkg::OFF_ROMSPD: rom_speed = v;
      default: ;
    endcase
  endtask

  // Work out the result of one accepted item and advance the mirror.
  task automatic predict_io_result(input cio_pkg::item_t it, output io_result_t res);
    logic [7:0] rd;
    rd = 8'h00;
    case (it.mode)
      cio_pkg::MODE_READ:  predict_read(it, rd);
      cio_pkg::MODE_WRITE: predict_write(it);
      cio_pkg::MODE_HBLANK: begin
        if (int_enable[4] && it.dot >= h_compare) begin
          if (!int_enable[5] || it.scanline == v_compare) begin
            irq_flag = 1;
            timer_flag = 1;
          end
        end
      end
      cio_pkg::MODE_VBLANK: begin
        nmi_status = 8'h82;
        if (int_enable[7]) nmi_request = 1;
        // Auto pad latch.
        if (int_enable[0]) begin
          for (int p = 0; p < PADS; p++) pad_shift[p] = pad_state[p];
        end
        if (int_enable[5] && !int_enable[4] && it.scanline == v_compare) begin
          irq_flag = 1;
          timer_flag = 1;
        end
      end
      cio_pkg::MODE_SETPAD:
        if (it.pad_index < PADS) pad_state[it.pad_index] = pad_layout(it.pad_buttons);
      cio_pkg::MODE_NMIACK: nmi_request = 0;
      default: ;  // unused modes change nothing
    endcase
    res.read_data   = rd;
    res.timer_irq   = irq_flag;
    res.nmi_pending = nmi_request;
  endtask

  function automatic logic [55:0] pack_item(input cio_pkg::item_t it);
    return {4'd0, it.pad_buttons, it.pad_index, it.dot, it.scanline,
            it.write_data, it.reg_offset, it.mode};
  endfunction

  function automatic cio_pkg::item_t mk_item(input logic [2:0] m, input logic [9:0] off,
                                             input logic [7:0] wd);
    cio_pkg::item_t it;
    it = '0;
    it.mode = m;
    it.reg_offset = off;
    it.write_data = wd;
    return it;
  endfunction

  function automatic int gap_len();
    // Mostly short gaps, sometimes none for a stretch, rarely long.
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic add_row(input cio_pkg::item_t it, input logic has_exp, input logic [7:0] rd,
                         input logic irq, input logic nmi);
    dir_row_t r;
    r.item = it;
    r.has_exp = has_exp;
    r.exp.read_data = rd;
    r.exp.timer_irq = irq;
    r.exp.nmi_pending = nmi;
    dir_rows = {dir_rows, r};
  endtask

  function automatic cio_pkg::item_t random_item();
    cio_pkg::item_t it;
    int    r;
    logic [9:0] hot [20];
    hot = '{cio_pkg::OFF_JOY0, cio_pkg::OFF_JOY1, cio_pkg::OFF_INTEN, cio_pkg::OFF_IOPORT,
            cio_pkg::OFF_MULA, cio_pkg::OFF_MULB, cio_pkg::OFF_DIVL, cio_pkg::OFF_DIVH,
            cio_pkg::OFF_DIVB, cio_pkg::OFF_HTL, cio_pkg::OFF_HTH, cio_pkg::OFF_VTL,
            cio_pkg::OFF_VTH, cio_pkg::OFF_ROMSPD, cio_pkg::OFF_NMIST, cio_pkg::OFF_TIMEUP,
            cio_pkg::OFF_HVBST, cio_pkg::OFF_QL, cio_pkg::OFF_RL, cio_pkg::OFF_P1H};
    it.mode        = 3'($urandom_range(5));
    it.reg_offset  = 10'($urandom);
    it.write_data  = 8'($urandom);
    it.scanline    = 9'($urandom);
    it.dot         = 9'($urandom);
    it.pad_index   = 1'($urandom);
    it.pad_buttons = 12'($urandom);
    r = $urandom_range(99);
    if (r < 80) it.reg_offset = hot[$urandom_range(19)];
    else if (r < 85) it.reg_offset = 10'($urandom_range(10'h21F, 10'h200));
    if (it.mode == cio_pkg::MODE_HBLANK || it.mode == cio_pkg::MODE_VBLANK) begin
      // Bias positions toward compare hits.
      if ($urandom_range(1)) it.dot = h_compare + 9'($urandom_range(3));
      if ($urandom_range(1)) it.scanline = v_compare;
    end
    if ($urandom_range(49) == 0) it.mode = 3'($urandom_range(7, 6));
    return it;
  endfunction

  // Push one item through the input channel; predict at the transfer.
  // Starts and ends at a falling edge; valid drops only when a gap follows.
  task automatic send_item(input cio_pkg::item_t it, input logic has_exp,
                           input io_result_t exp);
    io_result_t res;
    int         gap;
    gap = gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= pack_item(it);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_io_result(it, res);
    if (has_exp && res !== exp) begin
      $error("directed row disagrees with prediction: exp %h got %h", exp, res);
      failed = 1;
    end
    expected_results = {expected_results, (has_exp ? exp : res)};
    @(negedge clk);
  endtask

  // Output side: random stalls, compare each transfer with the oldest expectation.
  always @(negedge clk) begin
    if (rst_n) out_tready <= (gap_len() == 0) || ($urandom_range(1) == 0);
  end

  always @(posedge clk) begin
    io_result_t got;
    io_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.read_data   = out_tdata[7:0];
      got.timer_irq   = out_tdata[8];
      got.nmi_pending = out_tdata[9];
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        failed = 1;
      end else begin
        want = expected_results.pop_front();
        if (got.read_data !== want.read_data) begin
          $error("read_data exp %h got %h", want.read_data, got.read_data);
          failed = 1;
        end
        if (got.timer_irq !== want.timer_irq) begin
          $error("timer_irq exp %b got %b", want.timer_irq, got.timer_irq);
          failed = 1;
        end
        if (got.nmi_pending !== want.nmi_pending) begin
          $error("nmi_pending exp %b got %b", want.nmi_pending, got.nmi_pending);
          failed = 1;
        end
        if (out_tdata[15:10] !== '0) begin
          $error("out_tdata pad exp 0 got %h", out_tdata[15:10]);
          failed = 1;
        end
      end
    end
  end

  initial begin
    cio_pkg::item_t it;
    io_result_t none;
    failed = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    none = '0;
    clear_mirror();
    repeat (12) @(negedge clk);
    rst_n = 1;

    // Directed rows: reset values, extremes, divide by zero, pads, IRQ, NMI.
    add_row(mk_item(cio_pkg::MODE_READ, cio_pkg::OFF_NMIST, 8'h00), 1, 8'h00, 0, 0);
    add_row(mk_item(cio_pkg::MODE_READ, 10'h3FF, 8'h00), 1, 8'h00, 0, 0);
    add_row(mk_item(cio_pkg::MODE_WRITE, 10'h3FF, 8'hFF), 1, 8'h00, 0, 0);
    add_row(mk_item(cio_pkg::MODE_READ, 10'h220, 8'h00), 1, 8'hFF, 0, 0);
    add_row(mk_item(cio_pkg::MODE_WRITE, cio_pkg::OFF_MULA, 8'hFF), 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_WRITE, cio_pkg::OFF_MULB, 8'hFF), 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_READ, cio_pkg::OFF_RH, 8'h00), 1, 8'hFE, 0, 0);
    add_row(mk_item(cio_pkg::MODE_WRITE, cio_pkg::OFF_DIVL, 8'hFF), 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_WRITE, cio_pkg::OFF_DIVH, 8'hFF), 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_WRITE, cio_pkg::OFF_DIVB, 8'h00), 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_READ, cio_pkg::OFF_QH, 8'h00), 1, 8'hFF, 0, 0);
    add_row(mk_item(cio_pkg::MODE_READ, cio_pkg::OFF_RL, 8'h00), 1, 8'hFF, 0, 0);
    add_row(mk_item(cio_pkg::MODE_WRITE, cio_pkg::OFF_DIVB, 8'h07), 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_READ, cio_pkg::OFF_QL, 8'h00), 0, 0, 0, 0);
    it = mk_item(cio_pkg::MODE_SETPAD, 10'd0, 8'd0); it.pad_buttons = 12'hFFF;
    add_row(it, 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_WRITE, cio_pkg::OFF_JOY0, 8'h01), 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_READ, cio_pkg::OFF_JOY0, 8'h00), 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_READ, cio_pkg::OFF_JOY1, 8'h00), 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_WRITE, cio_pkg::OFF_INTEN, 8'hB1), 0, 0, 0, 0);
    it = mk_item(cio_pkg::MODE_VBLANK, 10'd0, 8'd0); it.scanline = 9'h1FF;
    add_row(it, 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_READ, cio_pkg::OFF_NMIST, 8'h00), 0, 0, 0, 0);
    it = mk_item(cio_pkg::MODE_HBLANK, 10'd0, 8'd0); it.dot = 9'h1FF;
    add_row(it, 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_READ, cio_pkg::OFF_TIMEUP, 8'h00), 0, 0, 0, 0);
    add_row(mk_item(cio_pkg::MODE_NMIACK, 10'd0, 8'd0), 0, 0, 0, 0);
    it = mk_item(3'd7, cio_pkg::OFF_HVBST, 8'd0); it.scanline = 9'd225; it.dot = 9'd274;
    add_row(it, 0, 0, 0, 0);
    it = mk_item(cio_pkg::MODE_READ, cio_pkg::OFF_HVBST, 8'd0);
    it.scanline = 9'd225; it.dot = 9'd274;
    add_row(it, 1, 8'hC0, 0, 0);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);
    for (int n = 0; n < N_RANDOM; n++) send_item(random_item(), 0, none);
    in_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
